>>> hdl/gbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the go-back-N window sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // chunk geometry: chunk size is a power of two, so index = bytes >> shift
  localparam int unsigned CHUNK_BYTES = 1024;
  localparam int unsigned CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int unsigned LAST_W      = 32 - CHUNK_SHIFT;
  localparam int unsigned MAX_WINDOW  = 32;

  // configuration register indexes
  localparam logic REG_WINDOW_LIMIT = 1'b0;
  localparam logic REG_FILE_BYTES   = 1'b1;

  // one acknowledgement round
  typedef struct packed {
    logic        ack_arrived;
    logic        ack_is_valid;
    logic [31:0] ack_sequence;
  } ack_t;

  // one result: a send request or the closing status
  typedef struct packed {
    logic        is_send;
    logic [22:0] chunk_index;
    logic [10:0] chunk_bytes;
    logic [31:0] base_after;
    logic        transfer_done;
    logic        last_of_round;
  } result_t;

  // round sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_ACK,
    ST_STATUS
  } seq_state_t;

endpackage

>>> hdl/go_back_n_window_sender_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_window_sender_unit
// Go-back-N sender window control: refills the window with send requests,
// applies the round's acknowledgement and closes with a status result.
// ----------------------------------------------------------------------------
// Order: input is taken in ST_IDLE, send requests are registered in ST_SEND,
// then ST_ACK and ST_STATUS; a round with no chunk to send gives the status only.
// Rounds: a round sends n requests (n <= 32); in_stall holds the input in every
// state but ST_IDLE, so a new round waits until the status result is loaded;
// one 33-bit index counter and one 32-bit subtractor serve the round sequencer.
// Reset: base and outstanding count cleared, window_limit = 5, file_bytes = 0.
module go_back_n_window_sender_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  gbn_pkg::ack_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output gbn_pkg::result_t out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data
);
  import gbn_pkg::*;

  localparam logic [5:0]  MAX_WIN_C   = 6'(MAX_WINDOW);
  localparam logic [10:0] FULL_CHUNK  = 11'(CHUNK_BYTES);

  // configuration
  logic [5:0]  window_limit;
  logic [31:0] file_bytes;

  // architectural state
  logic [31:0] window_start, window_start_next;
  logic [5:0]  outstanding_count, outstanding_count_next;

  // round working registers
  seq_state_t  state, state_next;
  ack_t        ack, ack_next;
  logic [5:0]  to_send, to_send_next;
  logic [5:0]  sent, sent_next;
  logic [32:0] idx, idx_next;

  // output register
  logic        out_valid_next;
  result_t     out_data_next;

  // derived values
  logic [LAST_W-1:0] last_chunk;
  logic [5:0]        win;
  logic [5:0]        oc_sum;
  logic [31:0]       diff;
  logic              load_ok;

  assign last_chunk = file_bytes[31:CHUNK_SHIFT];
  assign load_ok    = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE);

  // effective window, clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_limit == 6'd0) begin
      win = 6'd1;
    end else if (window_limit > MAX_WIN_C) begin
      win = MAX_WIN_C;
    end else begin
      win = window_limit;
    end
  end

  // ack arithmetic: outstanding-plus-sent sum and base-to-ack difference
  assign oc_sum = outstanding_count + sent;
  assign diff   = ack.ack_sequence - window_start;

  // sequencer: next state and outputs
  always_comb begin
    state_next             = state;
    ack_next               = ack;
    to_send_next           = to_send;
    sent_next              = sent;
    idx_next               = idx;
    window_start_next      = window_start;
    outstanding_count_next = outstanding_count;
    out_valid_next         = out_valid && out_stall;
    out_data_next          = out_data;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ack_next     = in_data;
          sent_next    = 6'd0;
          idx_next     = {1'b0, window_start} + 33'(outstanding_count);
          to_send_next = (outstanding_count < win) ? (win - outstanding_count) : 6'd0;
          state_next   = ST_SEND;
        end
      end
      ST_SEND: begin
        if (sent < to_send && idx <= 33'(last_chunk)) begin
          if (load_ok) begin
            out_valid_next              = 1'b1;
            out_data_next               = '0;
            out_data_next.is_send       = 1'b1;
            out_data_next.chunk_index   = idx[22:0];
            out_data_next.chunk_bytes   = (idx == 33'(last_chunk)) ?
                                          11'(file_bytes[CHUNK_SHIFT-1:0]) : FULL_CHUNK;
            idx_next                    = idx + 33'd1;
            sent_next                   = sent + 6'd1;
          end
        end else begin
          state_next = ST_ACK;
        end
      end
      ST_ACK: begin
        // higher valid ack advances the base, anything else resends the window
        if (ack.ack_arrived && ack.ack_is_valid && ack.ack_sequence > window_start) begin
          outstanding_count_next = (diff >= 32'(oc_sum)) ? 6'd0 : (oc_sum - diff[5:0]);
          window_start_next      = ack.ack_sequence;
        end else begin
          outstanding_count_next = 6'd0;
        end
        state_next = ST_STATUS;
      end
      ST_STATUS: begin
        if (load_ok) begin
          out_valid_next              = 1'b1;
          out_data_next               = '0;
          out_data_next.base_after    = window_start;
          out_data_next.transfer_done = (window_start > 32'(last_chunk));
          out_data_next.last_of_round = 1'b1;
          state_next                  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer state and round registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      window_start      <= '0;
      outstanding_count <= '0;
      out_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      window_start      <= window_start_next;
      outstanding_count <= outstanding_count_next;
      out_valid         <= out_valid_next;
    end
    ack      <= ack_next;
    to_send  <= to_send_next;
    sent     <= sent_next;
    idx      <= idx_next;
    out_data <= out_data_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= 6'd5;
      file_bytes   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LIMIT: window_limit <= cfg_data[5:0];
        REG_FILE_BYTES:   file_bytes   <= cfg_data;
        default:          ;
      endcase
    end
  end

endmodule
